/* hw/rtl/stfr_pkg.sv */
package stfr_pkg;

    localparam int PACKET_MAX_DEF = 256;

    localparam int BYTE_W = 8;
    localparam int TICK_W = 16;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h04;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h05;

    localparam logic [TICK_W-1:0] RELOAD_RESET = 16'd500;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_DONE   = 3'd1,
        ST_CSUM   = 3'd2,
        ST_OVFL   = 3'd3,
        ST_TOUT   = 3'd4,
        ST_SYNTAX = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_ESC   = 2'd3
    } t_phase;

endpackage

/* hw/rtl/stfr_if.sv */
interface stfr_in_if #(
    parameter int LEN_W = $clog2(stfr_pkg::PACKET_MAX_DEF + 2)
);
    logic                          valid;
    logic                          ready;
    stfr_pkg::t_kind               kind;
    logic [stfr_pkg::BYTE_W-1:0]   rx_byte;
    logic [LEN_W-1:0]              read_index;

    modport source (output valid, kind, rx_byte, read_index, input ready);
    modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

interface stfr_out_if #(
    parameter int LEN_W = $clog2(stfr_pkg::PACKET_MAX_DEF + 2)
);
    logic                          valid;
    logic                          ready;
    stfr_pkg::t_status             status;
    logic [LEN_W-1:0]              packet_length;
    logic [stfr_pkg::BYTE_W-1:0]   read_data;
    logic                          in_frame;

    modport source (output valid, status, packet_length, read_data, in_frame, input ready);
    modport sink   (input valid, status, packet_length, read_data, in_frame, output ready);
endinterface

/* hw/rtl/stuffed_frame_receiver.sv */
// Byte-stuffed frame receiver.
//
// Input channel i_in carries one request per item: a received byte, a timer
// tick, or a read of the packet store. Output channel o_out returns exactly
// one result per request: status, frame length (with done), stored byte (for
// reads) and whether a frame is still open afterwards.
//
// Throughput: one request per cycle while o_out is not held off. Frame
// state (phase, sum, count, timer) is updated in the accept cycle; the
// packet store is a single memory with one write port (data byte) and one
// registered read port (store read). A result passes through the store read
// stage and then the output register before it is on o_out.
//
// Stall: when o_out is held off, one further request is still taken into
// the read stage; after that i_in.ready drops until the output drains.
// Reset (synchronous, i_rst_n low): phase idle, sum and count zero, timer
// and timeout_reload back to 500, pipeline empty. The store is not cleared;
// it holds whatever was last written. i_cfg_we writes timeout_reload.
module stuffed_frame_receiver #(
    parameter int PACKET_MAX = stfr_pkg::PACKET_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stfr_pkg::TICK_W-1:0]   i_cfg_data,
    stfr_in_if.sink                       i_in,
    stfr_out_if.source                    o_out
);

    localparam int LEN_W  = $clog2(PACKET_MAX + 2);
    localparam int ADDR_W = $clog2(PACKET_MAX + 1);
    localparam int DEPTH  = PACKET_MAX + 1;
    localparam logic [LEN_W-1:0] COUNT_FULL = LEN_W'(PACKET_MAX + 1);
    localparam logic [LEN_W-1:0] INDEX_MAX  = LEN_W'(PACKET_MAX);

    // Frame state
    stfr_pkg::t_phase                 r_phase, n_phase;
    logic [stfr_pkg::BYTE_W-1:0]      r_sum, n_sum;
    logic [LEN_W-1:0]                 r_count, n_count;
    logic [stfr_pkg::TICK_W-1:0]      r_ticks, n_ticks;
    logic [stfr_pkg::TICK_W-1:0]      r_reload;

    // Packet store
    logic [stfr_pkg::BYTE_W-1:0]      mem [DEPTH];
    logic [stfr_pkg::BYTE_W-1:0]      r_mem_q;

    // Read stage
    logic                             r_s1_valid;
    stfr_pkg::t_status                r_s1_status;
    logic [LEN_W-1:0]                 r_s1_length;
    logic                             r_s1_rd;
    logic                             r_s1_in_frame;

    // Output register
    logic                             r_s2_valid;
    stfr_pkg::t_status                r_s2_status;
    logic [LEN_W-1:0]                 r_s2_length;
    logic [stfr_pkg::BYTE_W-1:0]      r_s2_data;
    logic                             r_s2_in_frame;

    logic                             w_accept;
    logic                             w_s1_move;
    logic                             w_full;
    logic                             w_is_byte;
    logic                             w_is_tick;
    logic [stfr_pkg::TICK_W-1:0]      w_ticks_dec;
    stfr_pkg::t_status                w_status;
    logic [LEN_W-1:0]                 w_length;
    logic                             w_we;
    logic                             w_rd;

    // Handshake: the read stage drains into the output register whenever
    // that register is empty or being taken.
    assign w_s1_move   = r_s1_valid && (!r_s2_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_s1_move;
    assign w_accept    = i_in.valid && i_in.ready;

    assign w_is_byte   = (i_in.kind == stfr_pkg::KIND_BYTE);
    assign w_is_tick   = (i_in.kind == stfr_pkg::KIND_TICK);
    assign w_full      = (r_count >= COUNT_FULL);
    assign w_ticks_dec = r_ticks - stfr_pkg::TICK_W'(1);

    // Next phase of the frame state machine
    always_comb begin
        n_phase = r_phase;
        if (w_is_byte) begin
            unique case (r_phase)
                stfr_pkg::PH_IDLE: begin
                    if (i_in.rx_byte == stfr_pkg::START_BYTE) n_phase = stfr_pkg::PH_START;
                end
                stfr_pkg::PH_START: begin
                    if (i_in.rx_byte == stfr_pkg::START_BYTE) n_phase = stfr_pkg::PH_DATA;
                end
                stfr_pkg::PH_DATA: begin
                    if (i_in.rx_byte == stfr_pkg::START_BYTE) begin
                        n_phase = stfr_pkg::PH_DATA;
                    end else if (i_in.rx_byte == stfr_pkg::END_BYTE) begin
                        n_phase = stfr_pkg::PH_IDLE;
                    end else if (i_in.rx_byte == stfr_pkg::ESC_BYTE) begin
                        n_phase = stfr_pkg::PH_ESC;
                    end else begin
                        n_phase = w_full ? stfr_pkg::PH_IDLE : stfr_pkg::PH_DATA;
                    end
                end
                stfr_pkg::PH_ESC: begin
                    n_phase = w_full ? stfr_pkg::PH_IDLE : stfr_pkg::PH_DATA;
                end
                default: n_phase = r_phase;
            endcase
        end else if (w_is_tick) begin
            if (r_phase != stfr_pkg::PH_IDLE && w_ticks_dec == '0) begin
                n_phase = stfr_pkg::PH_IDLE;
            end
        end
    end

    // Sum, count, timer, store write and result of this request
    always_comb begin
        n_sum    = r_sum;
        n_count  = r_count;
        n_ticks  = r_ticks;
        w_status = stfr_pkg::ST_NONE;
        w_length = '0;
        w_we     = 1'b0;
        w_rd     = 1'b0;
        unique case (i_in.kind)
            stfr_pkg::KIND_BYTE: begin
                n_ticks = r_reload;
                unique case (r_phase)
                    stfr_pkg::PH_IDLE: begin
                    end
                    stfr_pkg::PH_START: begin
                        if (i_in.rx_byte == stfr_pkg::START_BYTE) begin
                            n_sum   = '0;
                            n_count = '0;
                        end else begin
                            w_status = stfr_pkg::ST_SYNTAX;
                        end
                    end
                    stfr_pkg::PH_DATA, stfr_pkg::PH_ESC: begin
                        if (r_phase == stfr_pkg::PH_DATA
                                && i_in.rx_byte == stfr_pkg::START_BYTE) begin
                            n_sum   = '0;
                            n_count = '0;
                        end else if (r_phase == stfr_pkg::PH_DATA
                                && i_in.rx_byte == stfr_pkg::END_BYTE) begin
                            if (r_sum == '0) begin
                                w_status = stfr_pkg::ST_DONE;
                                w_length = r_count;
                            end else begin
                                w_status = stfr_pkg::ST_CSUM;
                            end
                        end else if (r_phase == stfr_pkg::PH_DATA
                                && i_in.rx_byte == stfr_pkg::ESC_BYTE) begin
                        end else if (w_full) begin
                            w_status = stfr_pkg::ST_OVFL;
                        end else begin
                            n_sum   = r_sum + i_in.rx_byte;
                            n_count = r_count + LEN_W'(1);
                            w_we    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            stfr_pkg::KIND_TICK: begin
                if (r_phase != stfr_pkg::PH_IDLE) begin
                    n_ticks = w_ticks_dec;
                    if (w_ticks_dec == '0) w_status = stfr_pkg::ST_TOUT;
                end
            end
            stfr_pkg::KIND_READ: begin
                w_rd = (i_in.read_index <= INDEX_MAX);
            end
            default: begin
            end
        endcase
    end

    // Frame state registers; advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= stfr_pkg::PH_IDLE;
            r_sum    <= '0;
            r_count  <= '0;
            r_ticks  <= stfr_pkg::RELOAD_RESET;
            r_reload <= stfr_pkg::RELOAD_RESET;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_ticks <= n_ticks;
            end
            if (i_cfg_we) r_reload <= i_cfg_data;
        end
    end

    // Packet store: write the data byte at the fill position, read on store
    // requests. Reads and writes come from different requests, so one edge
    // never carries both and a read always sees earlier writes.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) mem[r_count[ADDR_W-1:0]] <= i_in.rx_byte;
        if (w_accept && w_rd) r_mem_q <= mem[i_in.read_index[ADDR_W-1:0]];
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status   <= w_status;
            r_s1_length   <= w_length;
            r_s1_rd       <= w_rd;
            r_s1_in_frame <= (n_phase != stfr_pkg::PH_IDLE);
        end
    end

    // Output register; hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_status   <= r_s1_status;
            r_s2_length   <= r_s1_length;
            r_s2_data     <= r_s1_rd ? r_mem_q : '0;
            r_s2_in_frame <= r_s1_in_frame;
        end
    end

    assign o_out.valid         = r_s2_valid;
    assign o_out.status        = r_s2_status;
    assign o_out.packet_length = r_s2_length;
    assign o_out.read_data     = r_s2_data;
    assign o_out.in_frame      = r_s2_in_frame;

`ifndef SYNTHESIS
    // Store writes stay inside the store
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_we) |-> (r_count < COUNT_FULL))
        else $error("store write beyond last entry");

    // Every ending status leaves the receiver idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && (r_s2_status == stfr_pkg::ST_DONE
            || r_s2_status == stfr_pkg::ST_CSUM
            || r_s2_status == stfr_pkg::ST_OVFL
            || r_s2_status == stfr_pkg::ST_TOUT)) |-> !r_s2_in_frame)
        else $error("frame still open after ending status");

    // Both stages full and sink stalled: take no new request
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && !o_out.ready) |-> !i_in.ready)
        else $error("request taken with pipeline full");

    // A reported length never exceeds the store depth
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_status == stfr_pkg::ST_DONE) |-> (r_s2_length <= COUNT_FULL))
        else $error("frame length beyond store depth");
`endif

endmodule
